@@ hw/rtl/pap_pkg.sv @@
// pap_pkg: shared constants, status codes and controller/datapath interface structs
// for the polygon area and perimeter block. No dependencies.
package pap_pkg;

  // defaults for the top-level parameters
  localparam int unsigned DEF_MAX_POINTS  = 1024;
  localparam int unsigned DEF_COORD_WIDTH = 20;

  // fixed result field widths
  localparam int unsigned AREA_W      = 55;  // signed trapezoid accumulator
  localparam int unsigned AREA_OUT_W  = 54;
  localparam int unsigned PERIM_W     = 32;
  localparam int unsigned VCOUNT_W    = 11;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_FIELD_W = AREA_OUT_W + PERIM_W + VCOUNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int unsigned MIN_POINTS = 3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // take the input beat
    logic close_setup;  // set up closing edge back to first vertex
    logic mul_h;        // prod = dx * h
    logic mul_xx;       // area += prod, prod = dx * dx
    logic mul_yy;       // rad = prod, prod = dy * dy
    logic sq_start;     // launch square root on dx^2 + dy^2
    logic perim_add;    // add edge length to perimeter
    logic emit;         // load result register, clear polygon
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;        // vertex store at limit
    logic empty;       // no vertex yet
    logic last;        // latched last-vertex mark
    logic overflowed;
    logic few;         // fewer than three vertices
    logic sq_done;
    logic out_busy;    // result register still held
  } stat_t;

endpackage

@@ hw/rtl/pap_isqrt.sv @@
// pap_isqrt: iterative integer square root, one result bit per cycle, floor.
// Depends on nothing but its parameter.
module pap_isqrt #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [2*COORD_WIDTH+1:0]      radicand,
  output logic [COORD_WIDTH:0]          root,
  output logic                          done
);

  localparam int unsigned RAD_W  = 2 * COORD_WIDTH + 2;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 4;
  localparam int unsigned ITER   = ROOT_W;
  localparam int unsigned CNT_W  = $clog2(ITER + 1);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(ITER);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= rad << 2;
      rem  <= take ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], take};
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> cnt == '0) else $error("isqrt restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("isqrt done longer than one cycle");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0 && !start) |=> cnt == $past(cnt) - 1'b1)
    else $error("isqrt step counter skipped");
`endif

endmodule

@@ hw/rtl/pap_datapath.sv @@
// pap_datapath: vertex registers, shared multiplier, accumulators, square root
// and result register. Uses pap_pkg and pap_isqrt; driven by pap_ctrl.
module pap_datapath #(
  parameter int unsigned MAX_POINTS  = pap_pkg::DEF_MAX_POINTS,
  parameter int unsigned COORD_WIDTH = pap_pkg::DEF_COORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [COORD_WIDTH-1:0]       x_in,
  input  logic signed [COORD_WIDTH-1:0]       y_in,
  input  logic                                last_in,
  input  pap_pkg::cmd_t                       cmd,
  output pap_pkg::stat_t                      st,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pap_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic [pap_pkg::STATUS_W-1:0]        m_tuser
);
  import pap_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned D_W    = COORD_WIDTH + 1;
  localparam int unsigned M_W    = COORD_WIDTH + 2;
  localparam int unsigned P_W    = 2 * M_W;
  localparam int unsigned SQ_W   = 2 * COORD_WIDTH + 1;
  localparam int unsigned RAD_W  = 2 * COORD_WIDTH + 2;
  localparam int unsigned ROOT_W = COORD_WIDTH + 1;
  localparam int unsigned PAD_W  = OUT_TDATA_W - OUT_FIELD_W;

  // polygon state
  logic signed [COORD_WIDTH-1:0] first_x, base_h, prev_x, prev_y;
  logic [CNT_W-1:0]              points_seen;
  logic                          overflowed;
  logic                          last_r;
  logic [AREA_W-1:0]             area_sum;
  logic [PERIM_W-1:0]            perim_sum;

  // edge work registers
  logic signed [D_W-1:0]         dx_r, dy_r;
  logic signed [M_W-1:0]         h_r;
  logic signed [P_W-1:0]         prod_r;
  logic [SQ_W-1:0]               rad_r;

  // result register
  logic [AREA_OUT_W-1:0]         area_o;
  logic [PERIM_W-1:0]            perim_o;
  logic [VCOUNT_W-1:0]           vcount_o;
  logic [STATUS_W-1:0]           status_o;

  logic signed [COORD_WIDTH-1:0] x2, y2;
  logic signed [D_W-1:0]         dx_next, dy_next;
  logic signed [M_W-1:0]         h_next;
  logic signed [M_W-1:0]         mul_a, mul_b;
  logic [RAD_W-1:0]              radicand;
  logic [ROOT_W-1:0]             root;
  logic                          sq_done;
  logic [PERIM_W:0]              perim_sum_ext;
  logic [AREA_W-1:0]             area_mag;

  // edge end point: incoming vertex, or first vertex when closing
  assign x2 = cmd.close_setup ? first_x : x_in;
  assign y2 = cmd.close_setup ? base_h  : y_in;

  assign dx_next = D_W'(x2) - D_W'(prev_x);
  assign dy_next = D_W'(y2) - D_W'(prev_y);
  assign h_next  = (M_W'(prev_y) - M_W'(base_h)) + (M_W'(y2) - M_W'(base_h));

  // one shared multiplier
  assign mul_a = cmd.mul_yy ? M_W'(dy_r) : M_W'(dx_r);
  assign mul_b = cmd.mul_h  ? h_r : (cmd.mul_xx ? M_W'(dx_r) : M_W'(dy_r));

  assign radicand      = RAD_W'(rad_r) + RAD_W'(prod_r[SQ_W-1:0]);
  assign perim_sum_ext = {1'b0, perim_sum} + (PERIM_W + 1)'(root);
  assign area_mag      = area_sum[AREA_W-1] ? (AREA_W'(0) - area_sum) : area_sum;

  pap_isqrt #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sq_start),
    .radicand (radicand),
    .root     (root),
    .done     (sq_done)
  );

  always_comb begin
    st.full       = points_seen >= CNT_W'(MAX_POINTS);
    st.empty      = points_seen == '0;
    st.last       = last_r;
    st.overflowed = overflowed;
    st.few        = points_seen < CNT_W'(MIN_POINTS);
    st.sq_done    = sq_done;
    st.out_busy   = m_tvalid && !m_tready;
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
      overflowed  <= 1'b0;
      last_r      <= 1'b0;
      area_sum    <= '0;
      perim_sum   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_r <= last_in;
        if (st.full) overflowed <= 1'b1;
        else         points_seen <= points_seen + 1'b1;
      end
      if (cmd.mul_xx)    area_sum  <= area_sum + AREA_W'(prod_r);
      if (cmd.perim_add) perim_sum <= perim_sum_ext[PERIM_W] ? '1
                                                             : perim_sum_ext[PERIM_W-1:0];
      if (cmd.emit) begin
        m_tvalid    <= 1'b1;
        points_seen <= '0;
        overflowed  <= 1'b0;
        area_sum    <= '0;
        perim_sum   <= '0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept && !st.full) begin
      prev_x <= x_in;
      prev_y <= y_in;
      if (st.empty) begin
        first_x <= x_in;
        base_h  <= y_in;
      end
    end
    if ((cmd.accept && !st.full && !st.empty) || cmd.close_setup) begin
      dx_r <= dx_next;
      dy_r <= dy_next;
      h_r  <= h_next;
    end
    if (cmd.mul_h || cmd.mul_xx || cmd.mul_yy) prod_r <= mul_a * mul_b;
    if (cmd.mul_yy) rad_r <= prod_r[SQ_W-1:0];
    if (cmd.emit) begin
      vcount_o <= VCOUNT_W'(points_seen);
      if (overflowed) begin
        area_o   <= '0;
        perim_o  <= '0;
        status_o <= STATUS_OVERFLOW;
      end else if (st.few) begin
        area_o   <= '0;
        perim_o  <= '0;
        status_o <= STATUS_FEW;
      end else begin
        area_o   <= area_mag[AREA_W-1:1];
        perim_o  <= perim_sum;
        status_o <= STATUS_OK;
      end
    end
  end

  assign m_tdata = {PAD_W'(0), vcount_o, perim_o, area_o};
  assign m_tuser = status_o;

`ifndef SYNTH
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    points_seen <= CNT_W'(MAX_POINTS)) else $error("vertex count past limit");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid && points_seen == '0 && !overflowed)
    else $error("emit did not load result and clear polygon");
  a_overflow_set: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && st.full && !cmd.emit) |=> overflowed)
    else $error("dropped vertex did not flag overflow");
`endif

endmodule

@@ hw/rtl/pap_ctrl.sv @@
// pap_ctrl: sequencer for the polygon block; steps each edge through the
// shared multiplier and square root. Uses pap_pkg; drives pap_datapath.
module pap_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  pap_pkg::stat_t  st,
  output pap_pkg::cmd_t   cmd
);
  import pap_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_CHECK   = 9'b000000010,
    ST_CLOSE   = 9'b000000100,
    ST_MUL_H   = 9'b000001000,
    ST_MUL_XX  = 9'b000010000,
    ST_MUL_YY  = 9'b000100000,
    ST_SQ_LOAD = 9'b001000000,
    ST_SQ_WAIT = 9'b010000000,
    ST_EMIT    = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   closing, closing_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    closing_next = closing;
    case (state)
      ST_IDLE: begin
        closing_next = 1'b0;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = (!st.full && !st.empty) ? ST_MUL_H : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!st.last)                      state_next = ST_IDLE;
        else if (st.overflowed || st.few)  state_next = ST_EMIT;
        else                               state_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        cmd.close_setup = 1'b1;
        closing_next    = 1'b1;
        state_next      = ST_MUL_H;
      end
      ST_MUL_H: begin
        cmd.mul_h  = 1'b1;
        state_next = ST_MUL_XX;
      end
      ST_MUL_XX: begin
        cmd.mul_xx = 1'b1;
        state_next = ST_MUL_YY;
      end
      ST_MUL_YY: begin
        cmd.mul_yy = 1'b1;
        state_next = ST_SQ_LOAD;
      end
      ST_SQ_LOAD: begin
        cmd.sq_start = 1'b1;
        state_next   = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (st.sq_done) begin
          cmd.perim_add = 1'b1;
          state_next    = closing ? ST_EMIT : ST_CHECK;
        end
      end
      ST_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next   = ST_IDLE;
        closing_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      closing <= 1'b0;
    end else begin
      state   <= state_next;
      closing <= closing_next;
    end
  end

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !st.out_busy) else $error("result overwritten while held");
  a_done_waiting: assert property (@(posedge clk) disable iff (rst)
    st.sq_done |-> state == ST_SQ_WAIT) else $error("square root done out of step");
  a_close_once: assert property (@(posedge clk) disable iff (rst)
    cmd.close_setup |-> !closing) else $error("closing edge set up twice");
`endif

endmodule

@@ hw/rtl/polygon_area_perimeter.sv @@
// Each vertex beat is taken only in the idle state and steps through: accept, three
// shared-multiplier passes, root load, bit-serial square root of dx^2 + dy^2 (the longest
// step), then a check; a first vertex, or one dropped at the limit, goes from accept to the check.
// For a proper polygon the last vertex adds the closing edge; every last vertex then loads the
// result register, held off while the previous result still waits.
// Reset (rst, synchronous, active high) clears the polygon and drops any result.
module polygon_area_perimeter #(
  parameter int unsigned MAX_POINTS  = pap_pkg::DEF_MAX_POINTS,
  parameter int unsigned COORD_WIDTH = pap_pkg::DEF_COORD_WIDTH
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // vertex beat
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // point_x, point_y (low to high), zero pad to bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
  input  logic                                     s_tlast,    // last_point
  // result beat
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // area, perimeter, vertex_count (low to high), zero pad to bytes
  output logic [pap_pkg::OUT_TDATA_W-1:0]          m_tdata,
  output logic [pap_pkg::STATUS_W-1:0]             m_tuser     // status
);
  import pap_pkg::*;

  cmd_t                          cmd;
  stat_t                         st;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  // unpack vertex fields; pad bits are ignored
  assign point_x = s_tdata[COORD_WIDTH-1:0];
  assign point_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

  // sequencer: one item at a time, ready only when idle
  pap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // arithmetic, polygon state and the result register
  pap_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .x_in     (point_x),
    .y_in     (point_y),
    .last_in  (s_tlast),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ bench/pap_checker.sv @@
`timescale 1ns / 1ps
// pap_checker: watches the vertex and result streams of polygon_area_perimeter,
// predicts each polygon's result and compares every result beat with it.
// Depends on pap_pkg for field widths and status codes.
module pap_checker #(
  parameter int unsigned MAX_POINTS  = pap_pkg::DEF_MAX_POINTS,
  parameter int unsigned COORD_WIDTH = pap_pkg::DEF_COORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
  input  logic                                s_tlast,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [pap_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic [pap_pkg::STATUS_W-1:0]        m_tuser,
  output int                                  mismatches,
  output int                                  outstanding
);

  localparam int unsigned S_W = ((2*COORD_WIDTH+7)/8)*8;
  localparam int unsigned AW  = pap_pkg::AREA_W;
  localparam int unsigned OW  = pap_pkg::AREA_OUT_W;
  localparam int unsigned PW  = pap_pkg::PERIM_W;
  localparam int unsigned VW  = pap_pkg::VCOUNT_W;
  localparam longint unsigned PERIM_CAP = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [OW-1:0]                area;
    logic [PW-1:0]                perimeter;
    logic [VW-1:0]                vertex_count;
    logic [pap_pkg::STATUS_W-1:0] status;
  } polygon_result_t;

  // running polygon
  longint          first_x, base_y, prev_x, prev_y;
  logic [AW-1:0]   twice_area;   // signed trapezoid sum, wraps in AW bits
  longint unsigned perim_acc;
  int unsigned     npts;
  bit              dropped;

  polygon_result_t pending_polygons[$];
  polygon_result_t want, got;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // floor square root, one result bit per pass
  function automatic longint unsigned isqrt_floor(input longint unsigned n);
    longint unsigned rem, root, b;
    rem  = n;
    root = 0;
    b    = 64'h4000_0000_0000_0000;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  task automatic add_edge(input longint x1, y1, x2, y2);
    longint          dx, dy, h;
    longint unsigned adx, ady;
    logic [AW-1:0]   term;
    dx   = x2 - x1;
    dy   = y2 - y1;
    h    = (y1 - base_y) + (y2 - base_y);
    adx  = (dx < 0) ? -dx : dx;
    ady  = (dy < 0) ? -dy : dy;
    term = AW'(dx * h);
    twice_area = twice_area + term;
    perim_acc  = perim_acc + isqrt_floor(adx * adx + ady * ady);
    if (perim_acc > PERIM_CAP) perim_acc = PERIM_CAP;
  endtask

  task automatic clear_polygon();
    first_x    = 0;
    base_y     = 0;
    prev_x     = 0;
    prev_y     = 0;
    twice_area = '0;
    perim_acc  = 0;
    npts       = 0;
    dropped    = 1'b0;
  endtask

  task automatic fold_vertex(input logic [S_W-1:0] beat, input logic is_last);
    logic signed [COORD_WIDTH-1:0] cx, cy;
    longint                        x, y;
    logic [AW-1:0]                 mag;
    polygon_result_t               r;
    cx = beat[COORD_WIDTH-1:0];
    cy = beat[2*COORD_WIDTH-1:COORD_WIDTH];
    x  = cx;
    y  = cy;
    if (npts >= MAX_POINTS) begin
      dropped = 1'b1;
    end else begin
      if (npts == 0) begin
        first_x = x;
        base_y  = y;
      end else begin
        add_edge(prev_x, prev_y, x, y);
      end
      prev_x = x;
      prev_y = y;
      npts++;
    end
    if (is_last) begin
      r = '0;
      r.vertex_count = npts[VW-1:0];
      if (dropped) begin
        r.status = pap_pkg::STATUS_OVERFLOW;
      end else if (npts < pap_pkg::MIN_POINTS) begin
        r.status = pap_pkg::STATUS_FEW;
      end else begin
        add_edge(prev_x, prev_y, first_x, base_y);
        mag = twice_area[AW-1] ? -twice_area : twice_area;
        r.area      = mag[AW-1:1];
        r.perimeter = perim_acc[PW-1:0];
        r.status    = pap_pkg::STATUS_OK;
      end
      pending_polygons = {pending_polygons, r};
      clear_polygon();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_polygon();
      pending_polygons.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.area         = m_tdata[OW-1:0];
        got.perimeter    = m_tdata[OW+PW-1:OW];
        got.vertex_count = m_tdata[OW+PW+VW-1:OW+PW];
        got.status       = m_tuser;
        if (pending_polygons.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected: %s%0d %s%0d %s%0d %s%0d",
                     $time, "area=", got.area, "perim=", got.perimeter,
                     "count=", got.vertex_count, "status=", got.status);
        end else begin
          want = pending_polygons.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch: exp area=%0d perim=%0d count=%0d status=%0d",
                       $time, want.area, want.perimeter, want.vertex_count, want.status);
              $display("%0t:                  got area=%0d perim=%0d count=%0d status=%0d",
                       $time, got.area, got.perimeter, got.vertex_count, got.status);
            end
          end
        end
      end
      if (s_tvalid && s_tready) fold_vertex(s_tdata, s_tlast);
    end
    outstanding = pending_polygons.size();
  end

endmodule

@@ bench/tb_polygon_area_perimeter.sv @@
`timescale 1ns / 1ps
// tb_polygon_area_perimeter: drives vertex beats into polygon_area_perimeter and
// gives the verdict; prediction and comparison live in pap_checker. Needs pap_pkg.
module tb_polygon_area_perimeter;

  localparam int unsigned COORD_W      = pap_pkg::DEF_COORD_WIDTH;
  localparam int unsigned MAX_PTS      = pap_pkg::DEF_MAX_POINTS;
  localparam int unsigned S_W          = ((2*COORD_W+7)/8)*8;
  // room for the last vertex's edge and the closing edge plus the result load, with margin
  localparam int unsigned DRAIN_CYCLES = 2*(COORD_W+7) + 8;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // handy coordinates: most negative, most positive, zero, minus one, one lsb
  localparam logic [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] C_ZERO = '0;
  localparam logic [COORD_W-1:0] C_NEG1 = '1;
  localparam logic [COORD_W-1:0] C_LSB  = 1;
  localparam logic [COORD_W-1:0] C_UNIT = 256;  // 1.0 in 8 fraction bits

  // how random vertices of one polygon are spread
  typedef enum int {SPREAD_FULL, SPREAD_LOCAL, SPREAD_EXTREME} spread_t;

  logic                              clk      = 1'b0;
  logic                              rst      = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [S_W-1:0]                    s_tdata  = '0;
  logic                              s_tlast  = 1'b0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [pap_pkg::OUT_TDATA_W-1:0]   m_tdata;
  logic [pap_pkg::STATUS_W-1:0]      m_tuser;

  int mismatches;
  int outstanding;
  int send_idle = 28;  // percent of beats the sender holds back
  int recv_idle = 62;  // percent of cycles the receiver stalls
  int cycles    = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  polygon_area_perimeter #(
    .MAX_POINTS  (MAX_PTS),
    .COORD_WIDTH (COORD_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  pap_checker #(
    .MAX_POINTS  (MAX_PTS),
    .COORD_WIDTH (COORD_W)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("polygon_area_perimeter regression: fail");
      $finish;
    end
  end

  // One vertex beat. Entered and left at a falling edge; tvalid is only
  // dropped when the sender chooses to idle, so it never toggles within a step.
  task automatic send_point(input logic [COORD_W-1:0] x, y, input logic is_last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender goes quiet until every predicted result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input spread_t spread,
                                                    input logic [COORD_W-1:0] centre);
    logic [31:0] r;
    r = $urandom();
    case (spread)
      SPREAD_FULL:  return r[COORD_W-1:0];
      // small moves round a centre: short edges, small areas, fraction bits busy
      SPREAD_LOCAL: return centre + COORD_W'($urandom_range(0, 4095)) - COORD_W'(2048);
      default: begin
        case (r[2:0])
          3'd0, 3'd5: return C_MIN;
          3'd1, 3'd6: return C_MAX;
          3'd2:       return C_ZERO;
          3'd3:       return C_NEG1;
          default:    return C_LSB;
        endcase
      end
    endcase
  endfunction

  // Random polygons until the vertex budget is spent. Mostly proper polygons,
  // a tenth short ones (status few) and a tenth larger ones.
  task automatic random_polygons(input int budget);
    int                 sent, n, pick;
    spread_t            spread;
    logic [31:0]        r;
    logic [COORD_W-1:0] centre;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 10)      n = $urandom_range(1, 2);
      else if (pick < 90) n = $urandom_range(3, 10);
      else                n = $urandom_range(11, 40);
      spread = spread_t'($urandom_range(0, 2));
      r      = $urandom();
      centre = r[COORD_W-1:0];
      for (int i = 0; i < n; i++)
        send_point(pick_coord(spread, centre), pick_coord(spread, centre), i == n - 1);
      sent += n;
    end
  endtask

  // Large polygon bouncing round the four corners: big edges and a big sum.
  // Past MAX_PTS vertices the extra ones are dropped and overflow is flagged.
  task automatic big_polygon(input int n);
    logic [COORD_W-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      x = (i % 4 == 0 || i % 4 == 3) ? C_MIN + COORD_W'($urandom_range(0, 255))
                                     : C_MAX - COORD_W'($urandom_range(0, 255));
      y = (i % 4 < 2) ? C_MIN + COORD_W'($urandom_range(0, 255))
                      : C_MAX - COORD_W'($urandom_range(0, 255));
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed ---
    // lone vertex and a pair: too few for a polygon
    send_point(C_MAX, C_MIN, 1'b1);
    send_point(C_ZERO, C_ZERO, 1'b0);
    send_point(C_NEG1, C_NEG1, 1'b1);
    // full-scale triangle, anticlockwise (negative sum) then clockwise
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, 1'b1);
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, 1'b0);
    send_point(C_MAX, C_MIN, 1'b1);
    // full-scale square, largest area the coordinates allow
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(C_MAX, C_MAX, 1'b0);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MIN, 1'b1);
    // all on one spot: zero area, zero perimeter
    send_point(C_NEG1, C_NEG1, 1'b0);
    send_point(C_NEG1, C_NEG1, 1'b0);
    send_point(C_NEG1, C_NEG1, 1'b1);
    // collinear: zero area, non-zero perimeter
    send_point(C_ZERO, C_ZERO, 1'b0);
    send_point(C_UNIT, C_UNIT, 1'b0);
    send_point(C_UNIT << 1, C_UNIT << 1, 1'b1);
    // one-lsb triangle: half-lsb area truncates away, root rounds down
    send_point(C_ZERO, C_ZERO, 1'b0);
    send_point(C_LSB, C_ZERO, 1'b0);
    send_point(C_ZERO, C_LSB, 1'b1);

    // --- random, sender sparse / receiver stalling ---
    random_polygons(165);
    drain();

    // --- random, roles swapped ---
    send_idle = 62;
    recv_idle = 28;
    random_polygons(165);
    drain();

    // --- flat out: a large corner-bouncing polygon, then random ---
    send_idle = 0;
    recv_idle = 0;
    big_polygon(40);
    random_polygons(165);
    drain();

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("polygon_area_perimeter regression: pass");
    end else begin
      $display("polygon_area_perimeter regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pap_pkg.sv
hw/rtl/pap_isqrt.sv
hw/rtl/pap_datapath.sv
hw/rtl/pap_ctrl.sv
hw/rtl/polygon_area_perimeter.sv
bench/pap_checker.sv
bench/tb_polygon_area_perimeter.sv
